>>> rtl/srpm_pkg.sv
// Shared constants, types and helpers for the stereo RMS and peak level meter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package srpm_pkg;

   localparam int SAMPLE_W    = 16;                  // width of a sample field on the port
   localparam int SAMPLE_BITS = 16;                  // bits of a sample that carry value
   localparam int MAX_FRAMES  = 4096;                // frame limit that closes a block
   localparam int OUT_W       = 16;                  // width of the level fields
   localparam int MAG_W       = SAMPLE_BITS;         // magnitude of one sample
   localparam int SQ_W        = 2 * MAG_W;           // square of one magnitude
   localparam int SUM_W       = 43;                  // saturating square sum
   localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
   localparam int ROOT_PAIRS  = (SUM_W + 1) / 2;     // radicand bit pairs
   localparam int RAD_W       = 2 * ROOT_PAIRS;
   localparam int ROOT_W      = ROOT_PAIRS;
   localparam int RREM_W      = ROOT_W + 2;
   localparam int DIV_CNT_W   = $clog2(SUM_W);
   localparam int ROOT_CNT_W  = $clog2(ROOT_PAIRS);

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef struct packed {
      logic             acc_en;   // a frame was accepted this cycle
      logic             start;    // close the block and begin the level math
      logic [CNT_W-1:0] count;    // frames in the closed block
   } lane_ctrl_type;

   typedef struct packed {
      logic             done;     // one-cycle pulse: rms and peak are valid
      logic [OUT_W-1:0] rms;
      logic [OUT_W-1:0] peak;
   } lane_stat_type;

   // Absolute value of a sample sign-extended from SAMPLE_BITS bits; the most
   // negative code maps to its true magnitude.
   function automatic logic [MAG_W-1:0] magnitude_of(input logic [SAMPLE_W-1:0] raw);
      logic [MAG_W-1:0] v;
      v = raw[SAMPLE_BITS-1:0];
      if (v[MAG_W-1]) begin
         return MAG_W'(~v + 1'b1);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/srpm_if.sv
// Request and response channel interfaces of the stereo level meter.
// Depends on srpm_pkg for the field widths.
`default_nettype none

interface srpm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [srpm_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [srpm_pkg::SAMPLE_W-1:0] right_sample;
   logic                                last_frame;

   modport source (output valid, output left_sample, output right_sample,
                   output last_frame, input ready);
   modport sink   (input valid, input left_sample, input right_sample,
                   input last_frame, output ready);
endinterface

interface srpm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srpm_pkg::OUT_W-1:0]    left_rms;
   logic [srpm_pkg::OUT_W-1:0]    right_rms;
   logic [srpm_pkg::OUT_W-1:0]    left_peak;
   logic [srpm_pkg::OUT_W-1:0]    right_peak;
   logic                          forced_end;

   modport source (output valid, output left_rms, output right_rms, output left_peak,
                   output right_peak, output forced_end, input ready);
   modport sink   (input valid, input left_rms, input right_rms, input left_peak,
                   input right_peak, input forced_end, output ready);
endinterface

`default_nettype wire

>>> rtl/srpm_lane.sv
// One channel lane: square accumulation, peak hold, bit-serial divide by the
// frame count and digit-by-digit square root. Depends on srpm_pkg.
`default_nettype none

module srpm_lane (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic signed [srpm_pkg::SAMPLE_W-1:0] sample,
   input  wire srpm_pkg::lane_ctrl_type              ctrl,
   output srpm_pkg::lane_stat_type                   stat
);

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_DIV  = 3'b010,
      L_ROOT = 3'b100
   } lane_state_type;

   lane_state_type                       state_ff, state_in;

   logic [srpm_pkg::MAG_W-1:0]           mag;
   logic [srpm_pkg::SQ_W-1:0]            sq_prod;
   logic [srpm_pkg::MAG_W-1:0]           mag_ff;
   logic [srpm_pkg::SQ_W-1:0]            sq_ff;
   logic                                 pend_ff;

   logic [srpm_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [srpm_pkg::SUM_W:0]             sum_add;
   logic [srpm_pkg::MAG_W-1:0]           peak_ff, peak_in;

   logic [srpm_pkg::SUM_W-1:0]           dvd_ff, dvd_in;
   logic [srpm_pkg::CNT_W:0]             rem_ff, rem_in, rem_shift;
   logic [srpm_pkg::CNT_W-1:0]           dvs_ff;
   logic                                 div_ge;
   logic [srpm_pkg::DIV_CNT_W-1:0]       dcnt_ff;

   logic [srpm_pkg::RAD_W-1:0]           rad_ff;
   logic [srpm_pkg::ROOT_W-1:0]          root_ff, root_in;
   logic [srpm_pkg::RREM_W-1:0]          rrem_ff, rrem_in, rrem_shift, trial;
   logic                                 root_ge;
   logic [srpm_pkg::ROOT_CNT_W-1:0]      rcnt_ff;

   logic [srpm_pkg::OUT_W-1:0]           rms_res_ff;
   logic [srpm_pkg::OUT_W-1:0]           peak_res_ff;
   logic                                 done_ff;

   // Square the magnitude at accept; the registered square is added in the next cycle.
   always_comb begin
      mag     = srpm_pkg::magnitude_of(sample);
      sq_prod = srpm_pkg::SQ_W'(mag) * srpm_pkg::SQ_W'(mag);
   end

   // Fold the pending square and magnitude into the running state.
   always_comb begin
      sum_add = {1'b0, sum_ff} + (srpm_pkg::SUM_W + 1)'(sq_ff);
      sum_in  = sum_ff;
      peak_in = peak_ff;
      if (pend_ff) begin
         sum_in = sum_add[srpm_pkg::SUM_W] ? srpm_pkg::SUM_MAX
                                           : sum_add[srpm_pkg::SUM_W-1:0];
         if (mag_ff > peak_ff) begin
            peak_in = mag_ff;
         end
      end
   end

   // Restoring divide step: one quotient bit per cycle.
   always_comb begin
      rem_shift = {rem_ff[srpm_pkg::CNT_W-1:0], dvd_ff[srpm_pkg::SUM_W-1]};
      div_ge    = rem_shift >= {1'b0, dvs_ff};
      rem_in    = div_ge ? rem_shift - {1'b0, dvs_ff} : rem_shift;
      dvd_in    = {dvd_ff[srpm_pkg::SUM_W-2:0], div_ge};
   end

   // Square root step: one root bit per radicand bit pair.
   always_comb begin
      rrem_shift = {rrem_ff[srpm_pkg::RREM_W-3:0], rad_ff[srpm_pkg::RAD_W-1 -: 2]};
      trial      = {root_ff, 2'b01};
      root_ge    = rrem_shift >= trial;
      rrem_in    = root_ge ? rrem_shift - trial : rrem_shift;
      root_in    = {root_ff[srpm_pkg::ROOT_W-2:0], root_ge};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (ctrl.start) begin
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            if (dcnt_ff == '0) begin
               state_in = L_ROOT;
            end
         end
         L_ROOT: begin
            if (rcnt_ff == '0) begin
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         pend_ff  <= 1'b0;
         sum_ff   <= '0;
         peak_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= ctrl.acc_en;
         done_ff  <= (state_ff == L_ROOT) && (rcnt_ff == '0);
         if (ctrl.start) begin
            sum_ff  <= '0;
            peak_ff <= '0;
         end else begin
            sum_ff  <= sum_in;
            peak_ff <= peak_in;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (ctrl.acc_en) begin
         mag_ff <= mag;
         sq_ff  <= sq_prod;
      end
      unique case (state_ff)
         L_IDLE: begin
            if (ctrl.start) begin
               dvd_ff      <= sum_in;
               rem_ff      <= '0;
               dvs_ff      <= ctrl.count;
               dcnt_ff     <= srpm_pkg::DIV_CNT_W'(srpm_pkg::SUM_W - 1);
               peak_res_ff <= srpm_pkg::OUT_W'(peak_in);
            end
         end
         L_DIV: begin
            dvd_ff  <= dvd_in;
            rem_ff  <= rem_in;
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               rad_ff  <= srpm_pkg::RAD_W'(dvd_in);
               root_ff <= '0;
               rrem_ff <= '0;
               rcnt_ff <= srpm_pkg::ROOT_CNT_W'(srpm_pkg::ROOT_PAIRS - 1);
            end
         end
         L_ROOT: begin
            rad_ff  <= {rad_ff[srpm_pkg::RAD_W-3:0], 2'b00};
            root_ff <= root_in;
            rrem_ff <= rrem_in;
            rcnt_ff <= rcnt_ff - 1'b1;
            if (rcnt_ff == '0) begin
               rms_res_ff <= srpm_pkg::OUT_W'(root_in);
            end
         end
         default: ;
      endcase
   end

   assign stat.done = done_ff;
   assign stat.rms  = rms_res_ff;
   assign stat.peak = peak_res_ff;

endmodule

`default_nettype wire

>>> rtl/stereo_rms_peak_meter_unit.sv
// Top level of the stereo block RMS and peak level meter: frame counter,
// block sequencing and the output register that merges both lanes.
// Depends on srpm_pkg, srpm_if (channel interfaces) and srpm_lane.
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    left_sample, right_sample, last_frame
//   rsp_chan  out   valid/ready    left_rms, right_rms, left_peak, right_peak, forced_end
//
// While no frame closes its block, a new request is taken in every cycle. A
// closing frame (marked last, or reaching MAX_FRAMES) holds off requests
// through the launch state, 43 steps of the bit-serial divider and 22 steps of
// the square root in each lane, run in parallel, the load into the output
// register and any wait in S_HOLD. Reset is synchronous and clears all
// sums, peaks and the frame count. A result waits in the output register while
// new requests are accepted; a second block end stalls only if it is not taken.
`default_nettype none

module stereo_rms_peak_meter_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   srpm_req_if.sink    req_chan,
   srpm_rsp_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      S_ACCUM  = 4'b0001,   // take frames
      S_LAUNCH = 4'b0010,   // last square lands, lanes start
      S_CALC   = 4'b0100,   // lanes divide and take the root
      S_HOLD   = 4'b1000    // result ready, output register still busy
   } meter_state_type;

   meter_state_type               state_ff, state_in;

   logic [srpm_pkg::CNT_W-1:0]    frames_ff;
   logic [srpm_pkg::CNT_W-1:0]    frames_next;
   logic [srpm_pkg::CNT_W-1:0]    count_ff;
   logic                          forced_ff;
   logic                          accept;
   logic                          limit;
   logic                          close;
   logic                          out_free;
   logic                          load;
   logic                          lanes_done;

   srpm_pkg::lane_ctrl_type       ctrl;
   srpm_pkg::lane_stat_type       stat_l, stat_r;

   logic                          rsp_valid_ff;
   logic [srpm_pkg::OUT_W-1:0]    left_rms_ff, right_rms_ff;
   logic [srpm_pkg::OUT_W-1:0]    left_peak_ff, right_peak_ff;
   logic                          forced_end_ff;

   // A block closes on its marked frame or on the frame that hits the limit.
   assign accept      = req_chan.valid && req_chan.ready;
   assign frames_next = frames_ff + 1'b1;
   assign limit       = frames_next >= srpm_pkg::CNT_W'(srpm_pkg::MAX_FRAMES);
   assign close       = accept && (req_chan.last_frame || limit);

   assign req_chan.ready = (state_ff == S_ACCUM);

   // Both lanes run in lock step; either done pulse stands for both.
   assign lanes_done = stat_l.done && stat_r.done;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      unique case (state_ff)
         S_ACCUM: begin
            if (close) begin
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (lanes_done) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = S_ACCUM;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_ACCUM;
            end
         end
         default: state_in = S_ACCUM;
      endcase
   end

   assign ctrl.acc_en = accept;
   assign ctrl.start  = (state_ff == S_LAUNCH);
   assign ctrl.count  = count_ff;

   srpm_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .sample (req_chan.left_sample),
      .ctrl   (ctrl),
      .stat   (stat_l)
   );

   srpm_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .sample (req_chan.right_sample),
      .ctrl   (ctrl),
      .stat   (stat_r)
   );

   // Sequencing and frame count.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCUM;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            frames_ff <= close ? '0 : frames_next;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Latch the block length and end cause; merge lane results on load.
   always_ff @(posedge clock) begin
      if (close) begin
         count_ff  <= frames_next;
         forced_ff <= limit && !req_chan.last_frame;
      end
      if (load) begin
         left_rms_ff   <= stat_l.rms;
         right_rms_ff  <= stat_r.rms;
         left_peak_ff  <= stat_l.peak;
         right_peak_ff <= stat_r.peak;
         forced_end_ff <= forced_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.left_rms   = left_rms_ff;
   assign rsp_chan.right_rms  = right_rms_ff;
   assign rsp_chan.left_peak  = left_peak_ff;
   assign rsp_chan.right_peak = right_peak_ff;
   assign rsp_chan.forced_end = forced_end_ff;

endmodule

`default_nettype wire
